/* rtl/csl_pkg.sv */
// Shared types, constants and character helpers for the comment-stripping lexer.
package csl_pkg;

	// Token buffer depth and the widths that follow from it
	localparam int MAX_TOKEN = 16;
	localparam int IDX_W     = $clog2(MAX_TOKEN);
	localparam int LEN_W     = $clog2(MAX_TOKEN + 1);

	// Reserved names: the keywords first, then the invalid name
	localparam int NAME_COUNT = 10;
	localparam int KW_COUNT   = 9;
	localparam int NAME_KDJ   = 9;
	localparam int NAME_CHARS = 8;

	localparam logic [8*NAME_CHARS-1:0] NAME_TEXT [NAME_COUNT] = '{
		"#include", "void", "include", "int", "float",
		"endl", "cout", "double", "return", "kdj"
	};
	localparam int NAME_LEN [NAME_COUNT] = '{8, 4, 7, 3, 5, 4, 4, 6, 6, 3};

	// Characters with a role in scanning
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SLASH  = 3'd1,
		MODE_LINE   = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_STAR   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		CLS_KEYWORD   = 3'd0,
		CLS_OPERATOR  = 3'd1,
		CLS_DELIMITER = 3'd2,
		CLS_NUMBER    = 3'd3,
		CLS_IDENT     = 3'd4,
		CLS_INVALID   = 3'd5,
		CLS_ERROR     = 3'd6
	} cls_t;

	// Progress of the number pattern over the buffered characters
	typedef enum logic [2:0] {
		NUM_EMPTY,
		NUM_INT,
		NUM_DOT,
		NUM_FRAC,
		NUM_BAD
	} num_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_TOKEN
	} state_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		cls_t       token_class;
		logic       token_end;
		logic       run_end;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic append;
		logic pop;
		logic emit_tok;
		logic emit_punct;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic have_char;
		logic head_sep;
		logic head_punct;
		logic tok_empty;
		logic flush_pend;
		logic idx_last;
	} dp_stat_t;

	// Controller to output stage
	typedef struct packed {
		logic push;
		logic finish;
	} oq_cmd_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c inside {"+", "-", "*", "/", ",", ";", ">", "<", "=",
			"(", ")", "[", "]", "{", "}", "&", "|"};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"], "_", "$"};
	endfunction

	function automatic cls_t single_class(input logic [7:0] c);
		cls_t r;
		if (c inside {"+", "-", "/", "=", "!"}) begin
			r = CLS_OPERATOR;
		end else if (c inside {"}", "{", "]", "[", ")", "(", ",", ";"}) begin
			r = CLS_DELIMITER;
		end else begin
			r = CLS_ERROR;
		end
		return r;
	endfunction

	// True when c equals character pos of reserved name k
	function automatic logic name_char_ok(input int k, input logic [LEN_W-1:0] pos,
			input logic [7:0] c);
		logic [8*NAME_CHARS-1:0] text;
		logic ok;
		text = NAME_TEXT[k] << (8 * (NAME_CHARS - NAME_LEN[k]));
		ok = 1'b0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			if ((int'(pos) == i) && (i < NAME_LEN[k])) begin
				ok = (text[(NAME_CHARS-1-i)*8 +: 8] == c);
			end
		end
		return ok;
	endfunction

endpackage

/* rtl/csl_dpath.sv */
// Datapath: comment scanning, pending characters, token buffer and classification.
module csl_dpath import csl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  in_item_t  char_item,
	output dp_stat_t  stat,
	output out_item_t res
);

	mode_t                 mode_q, mode_d;
	logic [7:0]            slot0_q, slot1_q, slot0_d, slot1_d;
	logic [1:0]            slot_cnt_q, slot_cnt_d;
	logic                  flush_q;
	logic [7:0]            tbuf_q [MAX_TOKEN];
	logic [LEN_W-1:0]      len_q;
	logic                  ovf_q;
	logic [IDX_W-1:0]      idx_q;
	logic [NAME_COUNT-1:0] name_ok_q, name_ok_d;
	num_t                  num_q, num_d;
	logic                  ident_q, ident_d;
	logic [7:0]            c;
	logic                  kw_hit, kdj_hit, tok_last, room, popping, tok_clear;
	cls_t                  one_cls, tok_cls;

	assign c = char_item.char_in;

	// Decode the incoming item: comment mode and characters it hands to the tokenizer
	always_comb begin
		mode_d     = mode_q;
		slot0_d    = c;
		slot1_d    = c;
		slot_cnt_d = 2'd0;
		case (mode_q)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else if (c == CH_STAR) begin
					mode_d = MODE_BLOCK;
				end else begin
					mode_d     = MODE_NORMAL;
					slot0_d    = CH_SLASH;
					slot_cnt_d = 2'd2;
				end
			end
			MODE_LINE: begin
				if (c == CH_NL) mode_d = MODE_NORMAL;
			end
			MODE_BLOCK: begin
				if (c == CH_STAR) mode_d = MODE_STAR;
			end
			MODE_STAR: begin
				if (c == CH_SLASH) begin
					mode_d = MODE_NORMAL;
				end else if (c != CH_STAR) begin
					mode_d = MODE_BLOCK;
				end
			end
			default: begin
				// normal scanning, also for any unknown mode
				if (c == CH_SLASH) begin
					mode_d = MODE_SLASH;
				end else begin
					slot_cnt_d = 2'd1;
				end
			end
		endcase
		// end of text: release a held slash and return to normal
		if (char_item.text_end) begin
			if (mode_d == MODE_SLASH) begin
				slot0_d    = CH_SLASH;
				slot_cnt_d = 2'd1;
			end
			mode_d = MODE_NORMAL;
		end
	end

	// Track the pattern checks as the head character is appended
	always_comb begin
		for (int k = 0; k < NAME_COUNT; k++) begin
			name_ok_d[k] = name_ok_q[k] && name_char_ok(k, len_q, slot0_q);
		end
		if (len_q == '0) begin
			ident_d = is_id_start(slot0_q);
		end else begin
			ident_d = ident_q && (is_id_start(slot0_q) || is_digit(slot0_q));
		end
		case (num_q)
			NUM_EMPTY: num_d = (slot0_q inside {["1":"9"]}) ? NUM_INT : NUM_BAD;
			NUM_INT: begin
				if (is_digit(slot0_q)) begin
					num_d = NUM_INT;
				end else if (slot0_q == CH_DOT) begin
					num_d = NUM_DOT;
				end else begin
					num_d = NUM_BAD;
				end
			end
			NUM_DOT:  num_d = is_digit(slot0_q) ? NUM_FRAC : NUM_BAD;
			NUM_FRAC: num_d = is_digit(slot0_q) ? NUM_FRAC : NUM_BAD;
			default:  num_d = NUM_BAD;
		endcase
	end

	// Classify the buffered token
	always_comb begin
		kw_hit = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (name_ok_q[k] && (len_q == LEN_W'(NAME_LEN[k]))) kw_hit = 1'b1;
		end
		kdj_hit = name_ok_q[NAME_KDJ] && (len_q == LEN_W'(NAME_LEN[NAME_KDJ]));
		one_cls = single_class(tbuf_q[0]);
		if (ovf_q) begin
			tok_cls = CLS_ERROR;
		end else if (kw_hit) begin
			tok_cls = CLS_KEYWORD;
		end else if ((len_q == LEN_W'(1)) && (one_cls != CLS_ERROR)) begin
			tok_cls = one_cls;
		end else if (kdj_hit) begin
			tok_cls = CLS_INVALID;
		end else if ((num_q == NUM_INT) || (num_q == NUM_FRAC)) begin
			tok_cls = CLS_NUMBER;
		end else if (ident_q) begin
			tok_cls = CLS_IDENT;
		end else begin
			tok_cls = CLS_ERROR;
		end
	end

	assign tok_last  = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;
	assign room      = len_q < LEN_W'(MAX_TOKEN);
	assign popping   = cmd.pop || cmd.append || cmd.emit_punct;
	assign tok_clear = cmd.emit_tok && tok_last;

	// Select the result: a punctuator or the next buffered character
	always_comb begin
		if (cmd.emit_punct) begin
			res.char_out    = slot0_q;
			res.token_class = single_class(slot0_q);
			res.token_end   = 1'b1;
		end else begin
			res.char_out    = tbuf_q[idx_q];
			res.token_class = tok_cls;
			res.token_end   = tok_last;
		end
		res.run_end = 1'b0;
	end

	assign stat.have_char  = slot_cnt_q != 2'd0;
	assign stat.head_sep   = is_sep(slot0_q);
	assign stat.head_punct = is_punct(slot0_q);
	assign stat.tok_empty  = len_q == '0;
	assign stat.flush_pend = flush_q;
	assign stat.idx_last   = tok_last;

	// Hold scan mode, pending characters and token bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			slot_cnt_q <= 2'd0;
			flush_q    <= 1'b0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			idx_q      <= '0;
			name_ok_q  <= '1;
			num_q      <= NUM_EMPTY;
			ident_q    <= 1'b1;
		end else begin
			if (cmd.load) begin
				mode_q     <= mode_d;
				slot_cnt_q <= slot_cnt_d;
				flush_q    <= char_item.text_end;
			end else if (popping) begin
				slot_cnt_q <= slot_cnt_q - 2'd1;
			end
			if (cmd.append) begin
				if (room) begin
					len_q     <= len_q + LEN_W'(1);
					name_ok_q <= name_ok_d;
					num_q     <= num_d;
					ident_q   <= ident_d;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (tok_clear) begin
				len_q     <= '0;
				ovf_q     <= 1'b0;
				idx_q     <= '0;
				name_ok_q <= '1;
				num_q     <= NUM_EMPTY;
				ident_q   <= 1'b1;
			end else if (cmd.emit_tok) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Store pending characters and buffered token text
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot0_q <= slot0_d;
			slot1_q <= slot1_d;
		end else if (popping) begin
			slot0_q <= slot1_q;
		end
		if (cmd.append && room) begin
			tbuf_q[len_q[IDX_W-1:0]] <= slot0_q;
		end
	end

endmodule

/* rtl/csl_outq.sv */
// Output stage: one held result awaiting its run_end flag, then the output register.
module csl_outq import csl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  oq_cmd_t   cmd,
	input  out_item_t res,
	output logic      room,
	output logic      tok_valid,
	input  logic      tok_ready,
	output out_item_t tok_item
);

	logic      hold_valid_q, out_valid_q, move;
	out_item_t hold_q, out_q;

	// Advance the held result once the next one arrives or the item is done
	assign move      = hold_valid_q && (cmd.push || cmd.finish);
	assign room      = !hold_valid_q || !out_valid_q || tok_ready;
	assign tok_valid = out_valid_q;
	assign tok_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (tok_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= '{char_out: hold_q.char_out, token_class: hold_q.token_class,
				token_end: hold_q.token_end, run_end: cmd.finish};
		end
		if (cmd.push) begin
			hold_q <= res;
		end
	end

endmodule

/* rtl/csl_ctrl.sv */
// Controller: sequences appends, token flushes and punctuator results for each item.
module csl_ctrl import csl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	output logic     char_ready,
	input  dp_stat_t stat,
	input  logic     oq_room,
	output dp_cmd_t  cmd,
	output oq_cmd_t  ocmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		ocmd       = '0;
		char_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				char_ready = 1'b1;
				if (char_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.have_char) begin
					if ((stat.head_sep || stat.head_punct) && !stat.tok_empty) begin
						state_d = ST_TOKEN;
					end else if (stat.head_sep) begin
						cmd.pop = 1'b1;
					end else if (stat.head_punct) begin
						if (oq_room) begin
							cmd.emit_punct = 1'b1;
							ocmd.push      = 1'b1;
						end
					end else begin
						cmd.append = 1'b1;
					end
				end else if (stat.flush_pend && !stat.tok_empty) begin
					state_d = ST_TOKEN;
				end else if (oq_room) begin
					// item done: mark its last result and take the next item
					ocmd.finish = 1'b1;
					char_ready  = 1'b1;
					if (char_valid) begin
						cmd.load = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TOKEN: begin
				if (oq_room) begin
					cmd.emit_tok = 1'b1;
					ocmd.push    = 1'b1;
					if (stat.idx_last) state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/comment_stripping_lexer_unit.sv */
// Top level of the comment-stripping lexer: controller, datapath and output stage.
//
// Characters enter one item at a time on the char channel; // and /* */ comments are
// removed and each finished token leaves as one tok item per character, with its class,
// a token_end mark on its last character and a run_end mark on the last result caused by
// an input item. The sequencer hands each character to the token stage; a token flush
// enters its flush state and reads the buffered characters out of the token buffer one
// per cycle while the output stage has room, and then the item is closed. A token holds
// at most 16 buffered characters, and the next item is taken only once the current one
// is closed. The final result of every item waits in a hold register until the item is
// done, so that run_end can be set; a stalled output side holds the sequencer only when
// both the hold register and the output register are full.
module comment_stripping_lexer_unit import csl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	output logic      tok_valid,
	input  logic      tok_ready,
	output out_item_t tok_item
);

	dp_cmd_t   dp_cmd;
	dp_stat_t  dp_stat;
	oq_cmd_t   oq_cmd;
	logic      oq_room;
	out_item_t dp_res;

	csl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.stat       (dp_stat),
		.oq_room    (oq_room),
		.cmd        (dp_cmd),
		.ocmd       (oq_cmd)
	);

	csl_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.char_item (char_item),
		.stat      (dp_stat),
		.res       (dp_res)
	);

	csl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (oq_cmd),
		.res       (dp_res),
		.room      (oq_room),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule

/* rtl/csl_checker.sv */
// Port-level checks for the comment-stripping lexer, bound to the top level.
module csl_checker import csl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      char_valid,
	input logic      char_ready,
	input in_item_t  char_item,
	input logic      tok_valid,
	input logic      tok_ready,
	input out_item_t tok_item
);

	// A waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(char_item))
		else $error("input item changed while waiting");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
		else $error("result changed while stalled");

	// The last result of an input item always closes a token
	a_run_end_tok: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.run_end |-> tok_item.token_end)
		else $error("run_end without token_end");

	// Delimiters are single-character tokens
	a_delim_single: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_class == CLS_DELIMITER) |-> tok_item.token_end)
		else $error("delimiter token longer than one character");

	// Number tokens hold only digits and a point
	a_number_chars: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_class == CLS_NUMBER) |->
			is_digit(tok_item.char_out) || (tok_item.char_out == CH_DOT))
		else $error("bad character in number token");

endmodule

bind comment_stripping_lexer_unit csl_checker u_csl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_ready (char_ready),
	.char_item  (char_item),
	.tok_valid  (tok_valid),
	.tok_ready  (tok_ready),
	.tok_item   (tok_item)
);

/* tb/testbench.sv */
// Self-checking testbench for the comment-stripping lexer: stimulus queue, driver, predictor and checker.
module testbench;
	import csl_pkg::*;

	// Reserved names as the predictor sees them: keywords first, the invalid name last
	localparam int KEYWORD_TOTAL = 9;
	localparam int INVALID_NAME  = 9;
	localparam int NAME_TOTAL    = 10;
	localparam int RUN_CAP       = 18;
	localparam string PUNCT_SET  = "+-*/,;><=()[]{}&|!";
	localparam string SEP_SET    = " \t\n";
	localparam string WORD_SET   =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$0123456789";
	localparam string BLOCK_SET  = "ab */*\n";

	string reserved_names [NAME_TOTAL] = '{
		"#include", "void", "include", "int", "float",
		"endl", "cout", "double", "return", "kdj"
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      char_valid = 1'b0;
	logic      char_ready;
	in_item_t  char_item = '0;
	logic      tok_valid;
	logic      tok_ready = 1'b0;
	out_item_t tok_item;

	comment_stripping_lexer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_item   (tok_item)
	);

	// Characters waiting to be sent and tokens characters still to arrive
	in_item_t  char_pending [$];
	out_item_t token_chars_due [$];

	// Predictor state
	mode_t       scan_q = MODE_NORMAL;
	logic [7:0]  tok_buf [MAX_TOKEN];
	int          tok_len = 0;
	bit          tok_ovf = 1'b0;
	int          run_base = 0;

	bit          char_taken = 1'b0;
	int          n_accepted = 0;
	int          n_sent = 0;
	int          n_bad = 0;
	int          n_cycle = 0;
	int          n_total = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Character classes of the scanner
	function automatic bit char_is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic bit char_starts_name(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
			(c == "_") || (c == "$");
	endfunction

	function automatic bit char_is_punct(logic [7:0] c);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < PUNCT_SET.len() - 1; i++) begin
			if (PUNCT_SET[i] == c) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic cls_t punct_class(logic [7:0] c);
		cls_t k;
		case (c)
			"+", "-", "/", "=", "!": k = CLS_OPERATOR;
			"}", "{", "]", "[", ")", "(", ",", ";": k = CLS_DELIMITER;
			default: k = CLS_ERROR;
		endcase
		return k;
	endfunction

	function automatic bit buf_matches(int k);
		string s;
		s = reserved_names[k];
		if (s.len() != tok_len) begin
			return 1'b0;
		end
		for (int i = 0; i < s.len(); i++) begin
			if (tok_buf[i] != s[i]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Nonzero lead digit, digits, then optionally a dot and at least one digit
	function automatic bit buf_is_number();
		int i;
		if ((tok_len == 0) || (tok_buf[0] < "1") || (tok_buf[0] > "9")) begin
			return 1'b0;
		end
		i = 1;
		while ((i < tok_len) && char_is_digit(tok_buf[i])) i++;
		if (i == tok_len) begin
			return 1'b1;
		end
		if (tok_buf[i] != ".") begin
			return 1'b0;
		end
		i++;
		if (i >= tok_len) begin
			return 1'b0;
		end
		while ((i < tok_len) && char_is_digit(tok_buf[i])) i++;
		return i == tok_len;
	endfunction

	function automatic bit buf_is_name();
		if ((tok_len == 0) || !char_starts_name(tok_buf[0])) begin
			return 1'b0;
		end
		for (int i = 1; i < tok_len; i++) begin
			if (!char_starts_name(tok_buf[i]) && !char_is_digit(tok_buf[i])) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic cls_t token_kind();
		if (tok_ovf) begin
			return CLS_ERROR;
		end
		for (int k = 0; k < KEYWORD_TOTAL; k++) begin
			if (buf_matches(k)) begin
				return CLS_KEYWORD;
			end
		end
		if ((tok_len == 1) && (punct_class(tok_buf[0]) != CLS_ERROR)) begin
			return punct_class(tok_buf[0]);
		end
		if (buf_matches(INVALID_NAME)) begin
			return CLS_INVALID;
		end
		if (buf_is_number()) begin
			return CLS_NUMBER;
		end
		if (buf_is_name()) begin
			return CLS_IDENT;
		end
		return CLS_ERROR;
	endfunction

	task automatic emit_char(logic [7:0] c, cls_t k, logic last);
		out_item_t r;
		if (token_chars_due.size() - run_base >= RUN_CAP) begin
			return;
		end
		r.char_out    = c;
		r.token_class = k;
		r.token_end   = last;
		r.run_end     = 1'b0;
		token_chars_due.insert(token_chars_due.size(), r);
	endtask

	task automatic flush_token();
		cls_t k;
		if (tok_len != 0) begin
			k = token_kind();
			for (int i = 0; i < tok_len; i++) begin
				emit_char(tok_buf[i], k, i + 1 == tok_len);
			end
		end
		tok_len = 0;
		tok_ovf = 1'b0;
	endtask

	task automatic put_char(logic [7:0] c);
		if ((c == " ") || (c == "\t") || (c == "\n")) begin
			flush_token();
		end else if (char_is_punct(c)) begin
			flush_token();
			emit_char(c, punct_class(c), 1'b1);
		end else if (tok_len < MAX_TOKEN) begin
			tok_buf[tok_len] = c;
			tok_len++;
		end else begin
			tok_ovf = 1'b1;
		end
	endtask

	// Advance the scanner by one character and queue the token characters it releases
	task automatic lex_step(in_item_t it);
		logic [7:0] c;
		c = it.char_in;
		run_base = token_chars_due.size();
		case (scan_q)
			MODE_NORMAL: begin
				if (c == "/") scan_q = MODE_SLASH;
				else put_char(c);
			end
			MODE_SLASH: begin
				if (c == "/") begin
					scan_q = MODE_LINE;
				end else if (c == "*") begin
					scan_q = MODE_BLOCK;
				end else begin
					scan_q = MODE_NORMAL;
					put_char("/");
					put_char(c);
				end
			end
			MODE_LINE: begin
				if (c == "\n") scan_q = MODE_NORMAL;
			end
			MODE_BLOCK: begin
				if (c == "*") scan_q = MODE_STAR;
			end
			default: begin
				if (c == "/") scan_q = MODE_NORMAL;
				else if (c != "*") scan_q = MODE_BLOCK;
			end
		endcase
		if (it.text_end) begin
			if (scan_q == MODE_SLASH) put_char("/");
			scan_q = MODE_NORMAL;
			flush_token();
		end
		if (token_chars_due.size() > run_base) begin
			token_chars_due[token_chars_due.size() - 1].run_end = 1'b1;
		end
	endtask

	task automatic add_char(logic [7:0] c, logic e);
		char_pending.insert(char_pending.size(), in_item_t'{char_in: c, text_end: e});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i], 1'b0);
		end
	endtask

	// Drive the next character or an idle cycle; drive the ready of the token side
	always @(negedge clk) begin
		n_cycle <= n_cycle + 1;
		if (arst_n && (!char_valid || char_taken)) begin
			if ((char_pending.size() != 0) &&
					!(($urandom_range(99) < 11) && !((n_sent >= 70) && (n_sent < 130)))) begin
				char_item  <= char_pending.pop_front();
				char_valid <= 1'b1;
				n_sent     <= n_sent + 1;
			end else begin
				char_valid <= 1'b0;
			end
		end
		if (arst_n) begin
			tok_ready <= !(($urandom_range(99) < 11) && !((n_cycle >= 250) && (n_cycle < 550)));
		end
	end

	// Predict on each accepted character, then check each accepted token character
	always @(posedge clk) begin
		out_item_t want;
		char_taken <= arst_n && char_valid && char_ready;
		if (arst_n && char_valid && char_ready) begin
			lex_step(char_item);
			n_accepted++;
		end
		if (arst_n && tok_valid && tok_ready) begin
			if (token_chars_due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) begin
					$display("%0t: unexpected item char %h class %0d end %b run %b", $time,
						tok_item.char_out, tok_item.token_class, tok_item.token_end,
						tok_item.run_end);
				end
			end else begin
				want = token_chars_due.pop_front();
				if ((tok_item.char_out !== want.char_out) ||
						(tok_item.token_class !== want.token_class) ||
						(tok_item.token_end !== want.token_end) ||
						(tok_item.run_end !== want.run_end)) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("%0t: mismatch exp char %h class %0d end %b run %b, got char %h class %0d end %b run %b",
							$time, want.char_out, want.token_class, want.token_end,
							want.run_end, tok_item.char_out, tok_item.token_class,
							tok_item.token_end, tok_item.run_end);
					end
				end
			end
		end
	end

	// Build the character stream, release reset, wait for the drain and report
	initial begin
		int unsigned kind;
		int unsigned n;
		int n_dir;
		int n_skip;
		logic [7:0] c;

		// Every class, joined comments, slash cases, star runs, byte extremes, flushes
		add_text("int(kdj=1.5/;a/*/**/b//\n\t");
		add_char(8'hFF, 1'b0);
		add_char(8'h00, 1'b1);
		add_char("/", 1'b1);
		n_dir = char_pending.size();
		n_skip = 0;

		while (char_pending.size() - n_dir - n_skip < 150) begin
			kind = $urandom_range(13);
			case (kind)
				0, 1: begin
					add_text(reserved_names[$urandom_range(NAME_TOTAL - 1)]);
				end
				2, 3: begin
					add_char(WORD_SET[$urandom_range(53)], 1'b0);
					repeat ($urandom_range(6)) add_char(WORD_SET[$urandom_range(63)], 1'b0);
				end
				4: begin
					c = ($urandom_range(9) == 0) ? 8'd48 : 8'($urandom_range(57, 49));
					add_char(c, 1'b0);
					repeat ($urandom_range(3)) add_char(8'($urandom_range(57, 48)), 1'b0);
					if ($urandom_range(1)) begin
						add_char(".", 1'b0);
						repeat ($urandom_range(3)) add_char(8'($urandom_range(57, 48)), 1'b0);
					end
					if ($urandom_range(7) == 0) add_text(".5");
				end
				5, 6: begin
					add_char(PUNCT_SET[$urandom_range(PUNCT_SET.len() - 1)], 1'b0);
				end
				7: begin
					add_char(SEP_SET[$urandom_range(2)], 1'b0);
				end
				8: begin
					add_text("//");
					n = $urandom_range(5);
					repeat (n) begin
						c = 8'($urandom_range(255));
						if (c == "\n") c = "x";
						add_char(c, 1'b0);
					end
					n_skip += n;
					if ($urandom_range(3) != 0) add_char("\n", 1'b0);
				end
				9: begin
					add_text("/*");
					n = $urandom_range(6);
					repeat (n) add_char(BLOCK_SET[$urandom_range(BLOCK_SET.len() - 1)], 1'b0);
					n_skip += n;
					if ($urandom_range(3) != 0) add_text("*/");
				end
				10: begin
					// Around the buffer depth, past it for truncation
					repeat ($urandom_range(20, 14)) add_char(WORD_SET[$urandom_range(63)], 1'b0);
				end
				11: begin
					repeat ($urandom_range(3, 1)) add_char(8'($urandom_range(255)), 1'b0);
				end
				12: begin
					add_char("/", 1'b0);
					add_char(8'($urandom_range(255)), 1'b0);
				end
				default: begin
					char_pending[char_pending.size() - 1].text_end = 1'b1;
				end
			endcase
			if ((kind != 7) && $urandom_range(1)) begin
				add_char(SEP_SET[$urandom_range(2)], 1'b0);
			end
		end
		char_pending[char_pending.size() - 1].text_end = 1'b1;
		n_total = char_pending.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total) @(negedge clk);
		while (token_chars_due.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if ((n_bad == 0) && (token_chars_due.size() == 0)) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* comment_stripping_lexer_unit.f */
rtl/csl_pkg.sv
rtl/csl_dpath.sv
rtl/csl_outq.sv
rtl/csl_ctrl.sv
rtl/comment_stripping_lexer_unit.sv
rtl/csl_checker.sv
tb/testbench.sv
